// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== hdl/tms_pkg.sv =====
// ----------------------------------------------------------------------------
// tms_pkg
// Types and constants shared by the turing machine step engine
// ----------------------------------------------------------------------------
package tms_pkg;

  localparam int unsigned TAPE_CELLS  = 64;
  localparam int unsigned NUM_STATES  = 16;
  localparam int unsigned NUM_SYMBOLS = 4;

  localparam int unsigned CELL_W  = $clog2(TAPE_CELLS);
  localparam int unsigned STATE_W = $clog2(NUM_STATES);
  localparam int unsigned SYM_W   = $clog2(NUM_SYMBOLS);
  localparam int unsigned MOVE_W  = 2;
  localparam int unsigned FAULT_W = 2;
  localparam int unsigned OP_W    = 3;

  localparam logic [SYM_W-1:0]  BLANK_RST = SYM_W'(3);
  localparam logic [CELL_W-1:0] HEAD_MAX  = CELL_W'(TAPE_CELLS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 3'd0,
    OP_WRITE = 3'd1,
    OP_RESET = 3'd2,
    OP_STEP  = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic [MOVE_W-1:0] {
    MOVE_NONE  = 2'd0,
    MOVE_LEFT  = 2'd1,
    MOVE_RIGHT = 2'd2
  } move_e;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_LEFT  = 2'd1,
    FAULT_RIGHT = 2'd2
  } fault_e;

  // transition entry, halt in the top bit
  typedef struct packed {
    logic               halt;
    logic [STATE_W-1:0] nxt;
    logic [MOVE_W-1:0]  move;
    logic [SYM_W-1:0]   wsym;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [CELL_W-1:0] rd_addr;
    logic              wr_en;
    logic [CELL_W-1:0] wr_addr;
    logic [SYM_W-1:0]  wr_data;
    logic              clr;
    logic [SYM_W-1:0]  clr_blank;
  } tape_req_t;

endpackage

// ===== hdl/tms_tape.sv =====
// ----------------------------------------------------------------------------
// tms_tape
// Tape memory with per-cell valid bits; an unwritten cell reads as the
// blank symbol latched at the last clear
// ----------------------------------------------------------------------------
module tms_tape (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tms_pkg::tape_req_t       req_i,
  output logic [tms_pkg::SYM_W-1:0] rd_sym_o
);
  import tms_pkg::*;

  logic [SYM_W-1:0]      tape_mem [TAPE_CELLS];
  logic [TAPE_CELLS-1:0] vld_q;
  logic [TAPE_CELLS-1:0] vld_d;
  logic [SYM_W-1:0]      clr_blank_q;
  logic [SYM_W-1:0]      rd_data_q;
  logic                  rd_vld_q;

  always_comb begin
    vld_d = vld_q;
    if (req_i.clr) begin
      vld_d = '0;
    end else if (req_i.wr_en) begin
      vld_d[req_i.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      clr_blank_q <= BLANK_RST;
      rd_vld_q    <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (req_i.clr) begin
        clr_blank_q <= req_i.clr_blank;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      tape_mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= tape_mem[req_i.rd_addr];
    end
  end

  assign rd_sym_o = rd_vld_q ? rd_data_q : clr_blank_q;

endmodule

// ===== hdl/turing_machine_step.sv =====
// ----------------------------------------------------------------------------
// turing_machine_step
// Single-tape turing machine engine: table load, tape access, machine reset
// and single steps, one status result per request
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  in        in   in_valid_i / in_ready_o    op_i .. cell_index_i
//  out       out  out_valid_o / out_ready_i  read_symbol_o .. fault_o
//  cfg       in   cfg_we_i                   cfg_wdata_i (blank symbol)
//
//  Each request is handled on acceptance and on execution: acceptance reads the
//  tape cell and the transition row of the current state, execution writes back
//  and loads the result register. One request is in flight at a time.
//  Execution waits while a previous result is not yet taken.
//  rst_ni clears head, state, halt, fault and marks every tape cell blank at
//  once through valid bits; the transition table is not cleared.
// ----------------------------------------------------------------------------
module turing_machine_step (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tms_pkg::SYM_W-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tms_pkg::OP_W-1:0]     op_i,
  input  logic [tms_pkg::STATE_W-1:0]  entry_state_i,
  input  logic [tms_pkg::SYM_W-1:0]    entry_symbol_i,
  input  logic [tms_pkg::SYM_W-1:0]    write_symbol_i,
  input  logic [tms_pkg::MOVE_W-1:0]   move_dir_i,
  input  logic [tms_pkg::STATE_W-1:0]  next_state_i,
  input  logic                         halts_i,
  input  logic [tms_pkg::CELL_W-1:0]   cell_index_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tms_pkg::SYM_W-1:0]    read_symbol_o,
  output logic [tms_pkg::SYM_W-1:0]    written_symbol_o,
  output logic [tms_pkg::MOVE_W-1:0]   move_done_o,
  output logic [tms_pkg::CELL_W-1:0]   head_position_o,
  output logic [tms_pkg::STATE_W-1:0]  machine_state_o,
  output logic                         halted_o,
  output logic [tms_pkg::FAULT_W-1:0]  fault_o
);
  import tms_pkg::*;

  `include "assert_macros.svh"

  logic [SYM_W-1:0]   blank_q;
  logic               busy_q;
  logic               in_fire;
  logic               exec_fire;

  // captured request
  logic [OP_W-1:0]    op_q;
  logic [STATE_W-1:0] est_q;
  logic [SYM_W-1:0]   esym_q;
  logic [CELL_W-1:0]  cell_q;
  entry_t             ent_in_q;

  // machine registers
  logic [CELL_W-1:0]  head_q, head_d;
  logic [STATE_W-1:0] state_q, state_d;
  logic               halt_q, halt_d;
  logic [FAULT_W-1:0] fault_q, fault_d;

  // transition table, one row of entries per state
  entry_t [NUM_SYMBOLS-1:0] tbl_mem [NUM_STATES];
  entry_t [NUM_SYMBOLS-1:0] row_q;
  logic                     tbl_we;

  tape_req_t          tape_req;
  logic [SYM_W-1:0]   cell_sym;
  entry_t             ent;

  logic [SYM_W-1:0]   res_rd, res_wr;
  logic [MOVE_W-1:0]  res_mv;

  logic               out_valid_q;
  logic [SYM_W-1:0]   out_rd_q, out_wr_q;
  logic [MOVE_W-1:0]  out_mv_q;
  logic [CELL_W-1:0]  out_head_q;
  logic [STATE_W-1:0] out_state_q;
  logic               out_halt_q;
  logic [FAULT_W-1:0] out_fault_q;

  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign exec_fire  = busy_q && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_q <= BLANK_RST;
    end else if (cfg_we_i) begin
      blank_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_fire) begin
      busy_q <= 1'b1;
    end else if (exec_fire) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q          <= op_i;
      est_q         <= entry_state_i;
      esym_q        <= entry_symbol_i;
      cell_q        <= cell_index_i;
      ent_in_q.wsym <= write_symbol_i;
      ent_in_q.move <= move_dir_i;
      ent_in_q.nxt  <= next_state_i;
      ent_in_q.halt <= halts_i;
    end
  end

  assign tbl_we = exec_fire && (op_q == OP_LOAD);

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[est_q][esym_q] <= ent_in_q;
    end
    if (in_fire) begin
      row_q <= tbl_mem[state_q];
    end
  end

  tms_tape u_tape (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (tape_req),
    .rd_sym_o (cell_sym)
  );

  assign ent = row_q[cell_sym];

  always_comb begin
    head_d   = head_q;
    state_d  = state_q;
    halt_d   = halt_q;
    fault_d  = fault_q;
    res_rd   = '0;
    res_wr   = '0;
    res_mv   = MOVE_NONE;

    tape_req.rd_en     = in_fire;
    tape_req.rd_addr   = (op_i == OP_READ) ? cell_index_i : head_q;
    tape_req.wr_en     = 1'b0;
    tape_req.wr_addr   = head_q;
    tape_req.wr_data   = ent.wsym;
    tape_req.clr       = 1'b0;
    tape_req.clr_blank = blank_q;

    unique case (op_q)
      OP_LOAD: begin
      end
      OP_WRITE: begin
        tape_req.wr_en   = exec_fire;
        tape_req.wr_addr = cell_q;
        tape_req.wr_data = ent_in_q.wsym;
      end
      OP_RESET: begin
        tape_req.clr = exec_fire;
        head_d  = '0;
        state_d = '0;
        halt_d  = 1'b0;
        fault_d = FAULT_NONE;
      end
      OP_STEP: begin
        res_rd = cell_sym;
        if (!halt_q) begin
          res_wr         = ent.wsym;
          tape_req.wr_en = exec_fire;
          unique case (ent.move)
            MOVE_LEFT: begin
              if (head_q == '0) begin
                halt_d  = 1'b1;
                fault_d = FAULT_LEFT;
              end else begin
                head_d = head_q - CELL_W'(1);
                res_mv = MOVE_LEFT;
              end
            end
            MOVE_RIGHT: begin
              if (head_q == HEAD_MAX) begin
                halt_d  = 1'b1;
                fault_d = FAULT_RIGHT;
              end else begin
                head_d = head_q + CELL_W'(1);
                res_mv = MOVE_RIGHT;
              end
            end
            default: begin
            end
          endcase
          if (ent.halt) begin
            halt_d = 1'b1;
          end else begin
            state_d = ent.nxt;
          end
        end
      end
      OP_READ: begin
        res_rd = cell_sym;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      state_q <= '0;
      halt_q  <= 1'b0;
      fault_q <= FAULT_NONE;
    end else if (exec_fire) begin
      head_q  <= head_d;
      state_q <= state_d;
      halt_q  <= halt_d;
      fault_q <= fault_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_rd_q    <= res_rd;
      out_wr_q    <= res_wr;
      out_mv_q    <= res_mv;
      out_head_q  <= head_d;
      out_state_q <= state_d;
      out_halt_q  <= halt_d;
      out_fault_q <= fault_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_symbol_o    = out_rd_q;
  assign written_symbol_o = out_wr_q;
  assign move_done_o      = out_mv_q;
  assign head_position_o  = out_head_q;
  assign machine_state_o  = out_state_q;
  assign halted_o         = out_halt_q;
  assign fault_o          = out_fault_q;

  `ASSERT_AT(a_accept_then_busy, clk_i, rst_ni, in_fire |=> busy_q)
  `ASSERT_AT(a_exec_gives_result, clk_i, rst_ni, exec_fire |=> out_valid_q && !busy_q)
  `ASSERT_AT(a_wait_holds_request, clk_i, rst_ni, busy_q && !exec_fire |=> busy_q && $stable(op_q))
  `ASSERT_NEVER(a_fault_without_halt, clk_i, rst_ni, !halt_q && (fault_q != FAULT_NONE))
  `ASSERT_NEVER(a_step_write_while_halted, clk_i, rst_ni, exec_fire && (op_q == OP_STEP) && halt_q && tape_req.wr_en)

endmodule

// ===== tb/turing_machine_step_tb.sv =====
// ----------------------------------------------------------------------------
// turing_machine_step_tb
// Self-checking bench for the turing machine step engine. A behavioral
// copy of the machine predicts the status of every accepted request; a
// checker compares each returned status field by field, in order. The run
// covers a directed pass, the right tape edge, blank symbol settings, a long
// output stall and random machine programs with and without random idling.
// ----------------------------------------------------------------------------
module turing_machine_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tms_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD      = 200;
  localparam int unsigned RANDOM_REQS    = 1400;
  localparam int unsigned STEADY_REQS    = 120;
  localparam int unsigned RULES          = NUM_STATES * NUM_SYMBOLS;

  localparam logic [OP_W-1:0]   OP_UNDEF_LO = OP_W'(OP_READ + 1);
  localparam logic [OP_W-1:0]   OP_UNDEF_HI = '1;
  localparam logic [MOVE_W-1:0] MOVE_UNDEF  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [STATE_W-1:0] est;
    logic [SYM_W-1:0]   esym;
    logic [SYM_W-1:0]   wsym;
    logic [MOVE_W-1:0]  mdir;
    logic [STATE_W-1:0] nst;
    logic               hlt;
    logic [CELL_W-1:0]  cidx;
  } req_t;

  typedef struct packed {
    logic [SYM_W-1:0]   rd_sym;
    logic [SYM_W-1:0]   wr_sym;
    logic [MOVE_W-1:0]  moved;
    logic [CELL_W-1:0]  head;
    logic [STATE_W-1:0] mstate;
    logic               halted;
    logic [FAULT_W-1:0] fault;
  } status_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [SYM_W-1:0]    cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [OP_W-1:0]     op_i;
  logic [STATE_W-1:0]  entry_state_i;
  logic [SYM_W-1:0]    entry_symbol_i;
  logic [SYM_W-1:0]    write_symbol_i;
  logic [MOVE_W-1:0]   move_dir_i;
  logic [STATE_W-1:0]  next_state_i;
  logic                halts_i;
  logic [CELL_W-1:0]   cell_index_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [SYM_W-1:0]    read_symbol_o;
  logic [SYM_W-1:0]    written_symbol_o;
  logic [MOVE_W-1:0]   move_done_o;
  logic [CELL_W-1:0]   head_position_o;
  logic [STATE_W-1:0]  machine_state_o;
  logic                halted_o;
  logic [FAULT_W-1:0]  fault_o;

  // machine image kept by the bench
  entry_t              rule_img    [RULES];
  bit                  rule_loaded [RULES];
  logic [SYM_W-1:0]    tape_img    [TAPE_CELLS];
  logic [CELL_W-1:0]   head_img;
  logic [STATE_W-1:0]  state_img;
  logic                halt_img;
  logic [FAULT_W-1:0]  fault_img;
  logic [SYM_W-1:0]    blank_img = BLANK_RST;

  status_t             status_q [$];
  status_t             exp_s;
  int unsigned         errors = 0;
  int unsigned         req_count = 0;
  int unsigned         right_pct = 50;
  int unsigned         quiet_cycles = 0;
  int unsigned         hold_left = 0;
  int unsigned         long_hold_reqs = 0;
  int unsigned         long_hold_seen = 0;
  bit                  tx_gaps = 1'b1;
  bit                  rx_gaps = 1'b1;

  turing_machine_step u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .entry_state_i    (entry_state_i),
    .entry_symbol_i   (entry_symbol_i),
    .write_symbol_i   (write_symbol_i),
    .move_dir_i       (move_dir_i),
    .next_state_i     (next_state_i),
    .halts_i          (halts_i),
    .cell_index_i     (cell_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .read_symbol_o    (read_symbol_o),
    .written_symbol_o (written_symbol_o),
    .move_done_o      (move_done_o),
    .head_position_o  (head_position_o),
    .machine_state_o  (machine_state_o),
    .halted_o         (halted_o),
    .fault_o          (fault_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void clear_image();
    for (int i = 0; i < TAPE_CELLS; i++) tape_img[i] = blank_img;
    head_img  = '0;
    state_img = '0;
    halt_img  = 1'b0;
    fault_img = FAULT_NONE;
  endfunction

  // advance the image by one request and return the status it reports
  function automatic status_t apply_request(req_t r);
    status_t s;
    entry_t  e;
    s = '0;
    case (r.op)
      OP_LOAD: begin
        rule_img[{r.est, r.esym}]    = {r.hlt, r.nst, r.mdir, r.wsym};
        rule_loaded[{r.est, r.esym}] = 1'b1;
      end
      OP_WRITE: tape_img[r.cidx] = r.wsym;
      OP_RESET: clear_image();
      OP_STEP: begin
        s.rd_sym = tape_img[head_img];
        if (!halt_img) begin
          e = rule_img[{state_img, s.rd_sym}];
          s.wr_sym = e.wsym;
          tape_img[head_img] = e.wsym;
          // a move past an edge still writes, but faults and keeps the head
          if (e.move == MOVE_LEFT) begin
            if (head_img == '0) begin
              halt_img  = 1'b1;
              fault_img = FAULT_LEFT;
            end else begin
              head_img = head_img - 1'b1;
              s.moved  = MOVE_LEFT;
            end
          end else if (e.move == MOVE_RIGHT) begin
            if (head_img == HEAD_MAX) begin
              halt_img  = 1'b1;
              fault_img = FAULT_RIGHT;
            end else begin
              head_img = head_img + 1'b1;
              s.moved  = MOVE_RIGHT;
            end
          end
          if (e.halt) halt_img = 1'b1;
          else state_img = e.nxt;
        end
      end
      OP_READ: s.rd_sym = tape_img[r.cidx];
      default: ;
    endcase
    s.head   = head_img;
    s.mstate = state_img;
    s.halted = halt_img;
    s.fault  = fault_img;
    return s;
  endfunction

  function automatic req_t rand_req(logic [OP_W-1:0] op);
    req_t        r;
    logic [31:0] bits;
    bits = $urandom;
    r    = bits[$bits(req_t)-1:0];
    r.op = op;
    return r;
  endfunction

  // transition entry with the move mix of the current program
  function automatic req_t rand_rule(logic [STATE_W-1:0] st, logic [SYM_W-1:0] sym);
    req_t        r;
    int unsigned pick;
    r      = rand_req(OP_LOAD);
    r.est  = st;
    r.esym = sym;
    pick   = $urandom_range(0, 99);
    if (pick < 5) r.mdir = MOVE_NONE;
    else if (pick < 8) r.mdir = MOVE_UNDEF;
    else if ($urandom_range(0, 99) < right_pct) r.mdir = MOVE_RIGHT;
    else r.mdir = MOVE_LEFT;
    r.hlt = ($urandom_range(0, 15) == 0);
    return r;
  endfunction

  // valid stays high after acceptance; the next action either drives a new
  // request or drops valid in the same step
  task automatic send_req(req_t r);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= r.op;
    entry_state_i  <= r.est;
    entry_symbol_i <= r.esym;
    write_symbol_i <= r.wsym;
    move_dir_i     <= r.mdir;
    next_state_i   <= r.nst;
    halts_i        <= r.hlt;
    cell_index_i   <= r.cidx;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    if (r.op <= OP_READ && !(r.op == OP_STEP && halt_img)) req_count++;
    status_q.push_back(apply_request(r));
  endtask

  task automatic send_cell(logic [OP_W-1:0] op, logic [CELL_W-1:0] cidx,
                           logic [SYM_W-1:0] sym);
    req_t r;
    r      = rand_req(op);
    r.cidx = cidx;
    r.wsym = sym;
    send_req(r);
  endtask

  // a step never looks up an entry that was never loaded
  task automatic send_step();
    if (!halt_img && !rule_loaded[{state_img, tape_img[head_img]}])
      send_req(rand_rule(state_img, tape_img[head_img]));
    send_req(rand_req(OP_STEP));
  endtask

  task automatic load_here(logic [SYM_W-1:0] ws, logic [MOVE_W-1:0] mv,
                           logic [STATE_W-1:0] nx, logic h);
    req_t r;
    r      = rand_req(OP_LOAD);
    r.est  = state_img;
    r.esym = tape_img[head_img];
    r.wsym = ws;
    r.mdir = mv;
    r.nst  = nx;
    r.hlt  = h;
    send_req(r);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (status_q.size() != 0);
  endtask

  task automatic write_blank(logic [SYM_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    blank_img   = v;
  endtask

  task automatic run_program();
    req_t        r;
    int unsigned n_steps;
    int unsigned k;
    right_pct = ($urandom_range(0, 3) == 0) ? 92 : $urandom_range(20, 80);
    repeat ($urandom_range(2, 10))
      send_req(rand_rule(STATE_W'($urandom_range(0, NUM_STATES - 1)),
                         SYM_W'($urandom_range(0, NUM_SYMBOLS - 1))));
    if ($urandom_range(0, 4) != 0) send_req(rand_req(OP_RESET));
    repeat ($urandom_range(0, 4))
      send_cell(OP_WRITE, CELL_W'($urandom_range(0, TAPE_CELLS - 1)),
                SYM_W'($urandom_range(0, NUM_SYMBOLS - 1)));
    n_steps = $urandom_range(8, 100);
    k = 0;
    while (k < n_steps && !(halt_img && $urandom_range(0, 2) == 0)) begin
      if ($urandom_range(0, 15) == 0) begin
        // stray request of any kind in the middle of a run
        r = rand_req(OP_W'($urandom_range(0, 7)));
        if (r.op == OP_STEP) send_step();
        else send_req(r);
      end else begin
        send_step();
      end
      k++;
    end
    repeat ($urandom_range(1, 4))
      send_cell(OP_READ, CELL_W'($urandom_range(0, TAPE_CELLS - 1)), '0);
  endtask

  task automatic test_directed();
    req_t r;
    // fresh tape after reset reads blank
    send_cell(OP_READ, '0, '0);
    send_cell(OP_READ, HEAD_MAX, '0);
    send_req(rand_req(OP_UNDEF_LO));
    send_req(rand_req(OP_UNDEF_HI));
    // left move at cell 0 faults, then a step on a halted machine
    load_here(2'd0, MOVE_LEFT, 4'd5, 1'b0);
    send_step();
    send_step();
    send_req(rand_req(OP_RESET));
    load_here(2'd2, MOVE_UNDEF, 4'd1, 1'b0);
    send_step();
    load_here(2'd1, MOVE_RIGHT, '1, 1'b0);
    send_step();
    // halting entry that also moves
    load_here(2'd0, MOVE_LEFT, 4'd9, 1'b1);
    send_step();
    send_cell(OP_READ, '0, '0);
    send_cell(OP_READ, CELL_W'(1), '0);
    r      = '1;
    r.op   = OP_WRITE;
    r.wsym = '0;
    send_req(r);
    r      = '0;
    r.op   = OP_WRITE;
    r.wsym = '1;
    send_req(r);
    send_cell(OP_READ, HEAD_MAX, '0);
    send_cell(OP_READ, '0, '0);
    send_req(rand_req(OP_RESET));
  endtask

  task automatic test_right_edge();
    req_t r;
    send_req(rand_req(OP_RESET));
    for (int s = 0; s < NUM_SYMBOLS; s++) begin
      r      = rand_req(OP_LOAD);
      r.est  = '0;
      r.esym = SYM_W'(s);
      r.mdir = MOVE_RIGHT;
      r.nst  = '0;
      r.hlt  = 1'b0;
      send_req(r);
    end
    while (!halt_img) send_step();
    send_step();
    send_cell(OP_READ, HEAD_MAX, '0);
  endtask

  task automatic test_blank_config();
    logic [SYM_W-1:0] v;
    for (int k = 0; k < 4; k++) begin
      if (k == 0) v = '0;
      else if (k == 1) v = '1;
      else v = SYM_W'($urandom_range(1, 2));
      wait_drained();
      write_blank(v);
      // new blank only shows after a machine reset
      send_cell(OP_READ, CELL_W'($urandom_range(0, TAPE_CELLS - 1)), '0);
      send_req(rand_req(OP_RESET));
      send_cell(OP_READ, '0, '0);
      send_cell(OP_READ, HEAD_MAX, '0);
      send_step();
    end
  endtask

  task automatic test_backpressure();
    tx_gaps = 1'b0;
    long_hold_reqs++;
    repeat (24) begin
      if ($urandom_range(0, 1) == 1) send_step();
      else send_cell(OP_READ, CELL_W'($urandom_range(0, TAPE_CELLS - 1)), '0);
    end
    // sender holds back until every status is back
    wait_drained();
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_programs();
    int unsigned stop_at;
    stop_at = req_count + RANDOM_REQS;
    while (req_count < stop_at) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        wait_drained();
        write_blank(SYM_W'($urandom_range(0, NUM_SYMBOLS - 1)));
      end
      run_program();
    end
  endtask

  task automatic test_steady();
    int unsigned stop_at;
    stop_at = req_count + STEADY_REQS;
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    while (req_count < stop_at) run_program();
  endtask

  // output side: random stall bursts plus one long hold on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (long_hold_seen != long_hold_reqs) begin
      long_hold_seen <= long_hold_reqs;
      out_ready_i    <= 1'b0;
      hold_left      <= LONG_HOLD - 1;
    end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= $urandom_range(0, 6);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i) begin
      if (status_q.size() == 0) begin
        $display("%0t: status with no request outstanding, expected none actual head %0d",
                 $time, head_position_o);
        errors++;
      end else begin
        exp_s = status_q.pop_front();
        check_field("read_symbol", 8'(exp_s.rd_sym), 8'(read_symbol_o));
        check_field("written_symbol", 8'(exp_s.wr_sym), 8'(written_symbol_o));
        check_field("move_done", 8'(exp_s.moved), 8'(move_done_o));
        check_field("head_position", 8'(exp_s.head), 8'(head_position_o));
        check_field("machine_state", 8'(exp_s.mstate), 8'(machine_state_o));
        check_field("halted", 8'(exp_s.halted), 8'(halted_o));
        check_field("fault", 8'(exp_s.fault), 8'(fault_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    op_i           = '0;
    entry_state_i  = '0;
    entry_symbol_i = '0;
    write_symbol_i = '0;
    move_dir_i     = '0;
    next_state_i   = '0;
    halts_i        = 1'b0;
    cell_index_i   = '0;
    clear_image();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_right_edge();
    test_blank_config();
    test_backpressure();
    test_random_programs();
    test_steady();
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (errors == 0 && status_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
